### hdl/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Widths, lane layout and shared types of the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;

    // Every divisor is at most six times the largest channel value.
    localparam int DIV_BITS  = CHANNEL_BITS + 3;
    // Quotient bits of n/d scaled by 2^(FRACTION_BITS+1), before rounding.
    localparam int QUOT_BITS = FRACTION_BITS + 2;
    localparam int NUM_CELLS = QUOT_BITS;
    localparam int LANES     = 3;

    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;
    localparam int LANE_LIG = 2;

    localparam logic [DIV_BITS-1:0] CHAN_MAX    = DIV_BITS'((1 << CHANNEL_BITS) - 1);
    localparam logic [DIV_BITS-1:0] FULL_SCALE2 = DIV_BITS'(2 * ((1 << CHANNEL_BITS) - 1));

    typedef logic [CHANNEL_BITS-1:0]  t_chan;
    typedef logic [FRACTION_BITS-1:0] t_frac;

    // One division in flight: partial remainder, divisor, the numerator bit
    // still to be shifted in, and the quotient collected so far.
    typedef struct packed {
        logic [DIV_BITS-1:0]  rem;
        logic [DIV_BITS-1:0]  den;
        logic                 fill;
        logic [QUOT_BITS-1:0] quot;
    } t_lane;

    typedef t_lane [LANES-1:0] t_lanes;

endpackage

### hdl/rgbhsl_ifs.sv
// ----------------------------------------------------------------------------
// rgbhsl interfaces
// Valid/ready channels for pixels, HSL results and the divider chain links.
// ----------------------------------------------------------------------------
interface rgbhsl_pix_if;
    import rgbhsl_pkg::*;
    logic  valid;
    logic  ready;
    t_chan red;
    t_chan green;
    t_chan blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsl_hsl_if;
    import rgbhsl_pkg::*;
    logic  valid;
    logic  ready;
    t_frac hue;
    t_frac saturation;
    t_frac lightness;
    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

interface rgbhsl_link_if;
    import rgbhsl_pkg::*;
    logic   valid;
    logic   ready;
    t_lanes data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/rgbhsl_front.sv
// ----------------------------------------------------------------------------
// rgbhsl_front
// Finds max and min of a pixel and sets up numerator and divisor of the
// hue, saturation and lightness divisions.
// ----------------------------------------------------------------------------
module rgbhsl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgbhsl_pix_if.sink    i_pix,
    rgbhsl_link_if.source o_link
);
    import rgbhsl_pkg::*;

    logic   r_valid;
    t_lanes r_data;
    t_lanes n_data;

    t_chan                 mx;
    t_chan                 mn;
    logic [CHANNEL_BITS:0] sum;
    logic [DIV_BITS-1:0]   sum_x;
    logic [DIV_BITS-1:0]   delta_x;
    logic [DIV_BITS-1:0]   r_x;
    logic [DIV_BITS-1:0]   g_x;
    logic [DIV_BITS-1:0]   b_x;
    logic [DIV_BITS-1:0]   hue_num;
    logic [DIV_BITS-1:0]   hue_den;
    logic [DIV_BITS-1:0]   sat_num;
    logic [DIV_BITS-1:0]   sat_den;
    logic                  grey;

    function automatic t_lane make_lane(input logic [DIV_BITS-1:0] num,
                                        input logic [DIV_BITS-1:0] den);
        t_lane lane;
        lane.rem  = num >> 1;
        lane.fill = num[0];
        lane.den  = den;
        lane.quot = '0;
        return lane;
    endfunction

    always_comb begin
        mx = i_pix.red;
        if (i_pix.green > mx) mx = i_pix.green;
        if (i_pix.blue > mx) mx = i_pix.blue;
        mn = i_pix.red;
        if (i_pix.green < mn) mn = i_pix.green;
        if (i_pix.blue < mn) mn = i_pix.blue;
    end

    assign sum     = {1'b0, mx} + {1'b0, mn};
    assign sum_x   = DIV_BITS'(sum);
    assign delta_x = DIV_BITS'(mx - mn);
    assign r_x     = DIV_BITS'(i_pix.red);
    assign g_x     = DIV_BITS'(i_pix.green);
    assign b_x     = DIV_BITS'(i_pix.blue);
    assign grey    = (mx == mn);

    // Hue numerator; the true value lies in [0, 6*delta), so wrapping
    // intermediate terms in DIV_BITS is harmless. Blue wins ties, then green.
    always_comb begin
        if (i_pix.blue == mx) begin
            hue_num = (delta_x << 2) + r_x - g_x;
        end else if (i_pix.green == mx) begin
            hue_num = (delta_x << 1) + b_x - r_x;
        end else if (i_pix.green < i_pix.blue) begin
            hue_num = (delta_x << 2) + (delta_x << 1) + g_x - b_x;
        end else begin
            hue_num = g_x - b_x;
        end
    end

    always_comb begin
        if (grey) begin
            // A zero over one keeps the divider chain free of special cases.
            hue_den = DIV_BITS'(1);
            sat_den = DIV_BITS'(1);
            sat_num = '0;
        end else begin
            hue_den = (delta_x << 2) + (delta_x << 1);
            sat_den = (sum_x <= CHAN_MAX) ? sum_x : FULL_SCALE2 - sum_x;
            sat_num = delta_x;
        end
    end

    always_comb begin
        n_data[LANE_HUE] = make_lane(grey ? '0 : hue_num, hue_den);
        n_data[LANE_SAT] = make_lane(sat_num, sat_den);
        n_data[LANE_LIG] = make_lane(sum_x, FULL_SCALE2);
    end

    assign i_pix.ready  = !r_valid || o_link.ready;
    assign o_link.valid = r_valid;
    assign o_link.data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.ready && i_pix.valid) begin
            r_data <= n_data;
        end
    end

endmodule

### hdl/rgbhsl_cell.sv
// ----------------------------------------------------------------------------
// rgbhsl_cell
// One restoring division step for all three lanes: shift the remainder,
// try the divisor, keep one quotient bit, pass the beat on.
// ----------------------------------------------------------------------------
module rgbhsl_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgbhsl_link_if.sink   i_link,
    rgbhsl_link_if.source o_link
);
    import rgbhsl_pkg::*;

    logic   r_valid;
    t_lanes r_data;
    t_lanes n_data;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic [DIV_BITS:0]   trial;
        logic [DIV_BITS:0]   diff;
        logic                take;

        assign trial = {i_link.data[k].rem, i_link.data[k].fill};
        assign diff  = trial - {1'b0, i_link.data[k].den};
        assign take  = (trial >= {1'b0, i_link.data[k].den});

        assign n_data[k].rem  = take ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
        assign n_data[k].den  = i_link.data[k].den;
        assign n_data[k].fill = 1'b0;
        assign n_data[k].quot = {i_link.data[k].quot[QUOT_BITS-2:0], take};
    end

    assign i_link.ready = !r_valid || o_link.ready;
    assign o_link.valid = r_valid;
    assign o_link.data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_link.ready) begin
            r_valid <= i_link.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_link.ready && i_link.valid) begin
            r_data <= n_data;
        end
    end

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data[LANE_HUE].rem < r_data[LANE_HUE].den) &&
                    (r_data[LANE_SAT].rem < r_data[LANE_SAT].den) &&
                    (r_data[LANE_LIG].rem < r_data[LANE_LIG].den))
        else $error("partial remainder not below divisor");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data[LANE_HUE].den != '0) && (r_data[LANE_SAT].den != '0) &&
                    (r_data[LANE_LIG].den == FULL_SCALE2))
        else $error("bad divisor in divider chain");

    a_fill_spent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !r_data[LANE_HUE].fill && !r_data[LANE_SAT].fill &&
                    !r_data[LANE_LIG].fill)
        else $error("numerator bit not consumed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("cell holds a beat after reset");

endmodule

### hdl/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Converts RGB pixels to hue, saturation and lightness fractions through a
// chain of division cells, with rounding and saturation at the output.
// ----------------------------------------------------------------------------
// Stages: one setup stage, 18 divider cells with one quotient bit each and
// one rounding output register. Throughput: one pixel per cycle unless the
// output stalls; every stage holds its own beat and advances whenever the
// stage after it is empty or moving.
// Reset: synchronous, active low; clears all valid flags, data is not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rgbhsl_pix_if.sink   i_pix,
    rgbhsl_hsl_if.source o_hsl
);
    import rgbhsl_pkg::*;

    rgbhsl_link_if u_link [NUM_CELLS+1] ();

    logic   r_valid;
    t_frac  r_hue;
    t_frac  r_sat;
    t_frac  r_lig;
    logic   tail_ready;
    logic   tail_valid;
    t_lanes tail_data;

    // Round half up from one extra quotient bit, then clip a full turn or
    // a ratio of one to the largest code.
    function automatic t_frac round_sat(input logic [QUOT_BITS-1:0] quot);
        logic [QUOT_BITS-1:0] bumped;
        bumped = quot + QUOT_BITS'(1);
        return bumped[QUOT_BITS-1] ? '1 : bumped[QUOT_BITS-2:1];
    endfunction

    rgbhsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_link  (u_link[0])
    );

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        rgbhsl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_link  (u_link[c]),
            .o_link  (u_link[c+1])
        );
    end

    assign tail_valid              = u_link[NUM_CELLS].valid;
    assign tail_data               = u_link[NUM_CELLS].data;
    assign tail_ready              = !r_valid || o_hsl.ready;
    assign u_link[NUM_CELLS].ready = tail_ready;

    assign o_hsl.valid      = r_valid;
    assign o_hsl.hue        = r_hue;
    assign o_hsl.saturation = r_sat;
    assign o_hsl.lightness  = r_lig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (tail_ready) begin
            r_valid <= tail_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_ready && tail_valid) begin
            r_hue <= round_sat(tail_data[LANE_HUE].quot);
            r_sat <= round_sat(tail_data[LANE_SAT].quot);
            r_lig <= round_sat(tail_data[LANE_LIG].quot);
        end
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Sends corner-case pixels and then bursts of random pixels into the
// converter while the result side stalls in changing patterns. Every pixel
// that is taken gets an HSL prediction. Each result beat must match the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
import rgbhsl_pkg::*;

localparam int CHAN_TOP = (1 << CHANNEL_BITS) - 1;
localparam longint FRAC_TOP = (64'd1 << FRACTION_BITS) - 1;

typedef struct packed {
    t_frac hue;
    t_frac saturation;
    t_frac lightness;
} t_hsl;

class hsl_tracker;
    t_hsl pending_hsl[$];
    int   errors;

    function new();
        errors = 0;
    endfunction

    // Rounded quotient num/den as a fraction, halves rounded up, clipped to
    // the largest fraction.
    function t_frac frac_of(int num, int den);
        longint q;
        if (den == 0) return '0;
        q = ((longint'(num) << FRACTION_BITS) + den / 2) / den;
        if (q > FRAC_TOP) q = FRAC_TOP;
        return t_frac'(q);
    endfunction

    function t_hsl predict_hsl(t_chan red, t_chan green, t_chan blue);
        int   r, g, b, mx, mn, sum, delta, h6;
        t_hsl res;
        r = red;
        g = green;
        b = blue;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = mx + mn;
        delta = mx - mn;
        res.lightness  = frac_of(sum, 2 * CHAN_TOP);
        res.hue        = '0;
        res.saturation = '0;
        if (delta != 0) begin
            res.saturation = frac_of(delta, (sum <= CHAN_TOP) ? sum : 2 * CHAN_TOP - sum);
            // On a tie for the largest channel the later one wins.
            h6 = 0;
            if (mx == r) h6 = (g - b) + ((g < b) ? 6 * delta : 0);
            if (mx == g) h6 = 2 * delta + (b - r);
            if (mx == b) h6 = 4 * delta + (r - g);
            if (h6 < 0) h6 = 0;
            res.hue = frac_of(h6, 6 * delta);
        end
        return res;
    endfunction

    function void note_pixel(t_chan red, t_chan green, t_chan blue);
        pending_hsl.push_back(predict_hsl(red, green, blue));
    endfunction

    function void flag(string field, t_frac want, t_frac got);
        errors++;
        if (errors <= 40)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_hsl(t_frac hue, t_frac saturation, t_frac lightness);
        t_hsl want;
        if (pending_hsl.size() == 0) begin
            errors++;
            if (errors <= 40)
                $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                         $time, hue, saturation, lightness);
            return;
        end
        want = pending_hsl.pop_front();
        if (hue !== want.hue) flag("hue", want.hue, hue);
        if (saturation !== want.saturation) flag("saturation", want.saturation, saturation);
        if (lightness !== want.lightness) flag("lightness", want.lightness, lightness);
    endfunction

    function int outstanding();
        return pending_hsl.size();
    endfunction
endclass

module testbench;

    localparam int RANDOM_PIXELS = 1650;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 30;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_count = 0;
    int   rx_phase = 0;
    int   rx_mode = 0;

    hsl_tracker tracker = new();

    rgbhsl_pix_if pix ();
    rgbhsl_hsl_if hsl ();

    rgb_to_hsl_converter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_hsl   (hsl)
    );

    // Greys, primaries, secondaries, ties for the largest channel, red on top
    // with blue above green, and sums on both sides of half scale.
    logic [23:0] corner_pixels[$] = '{
        24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00,
        24'h00ffff, 24'hff00ff, 24'h808080, 24'h7f7f7f, 24'h010101, 24'hfefefe,
        24'hff0001, 24'hff0100, 24'hffff80, 24'h80ffff, 24'hff80ff, 24'h7f0000,
        24'h80007f, 24'h800001, 24'hfe00ff, 24'h01fe00, 24'h0100ff, 24'h55aaff
    };

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The result side changes its stall behavior among four random modes.
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1;
        if (rx_phase % 50 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: hsl.ready <= 1'b1;
            1: hsl.ready <= ($urandom_range(0, 3) != 0);
            2: hsl.ready <= ($urandom_range(0, 3) == 0);
            default: hsl.ready <= (rx_phase % 7) < 4;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && hsl.valid && hsl.ready)
            tracker.check_hsl(hsl.hue, hsl.saturation, hsl.lightness);
    end

    // Called in the time step of a rising edge; returns in the step of the
    // edge that took the beat, with valid still high.
    task automatic send_pixel(t_chan r, t_chan g, t_chan b);
        pix.valid <= 1'b1;
        pix.red   <= r;
        pix.green <= g;
        pix.blue  <= b;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        tracker.note_pixel(r, g, b);
    endtask

    task automatic hold_off(int cycles);
        if (cycles > 0) begin
            pix.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic random_pixel(output t_chan r, output t_chan g, output t_chan b);
        int    kind;
        t_chan hi, lo, mid;
        r = $urandom;
        g = $urandom;
        b = $urandom;
        kind = $urandom_range(0, 9);
        hi = $urandom;
        lo = $urandom_range(0, hi);
        mid = $urandom_range(lo, hi);
        case (kind)
            5: begin
                g = r;
                b = r;
            end
            6: begin
                // Two channels tie for the largest value.
                case ($urandom_range(0, 2))
                    0: begin r = hi; g = hi; b = lo; end
                    1: begin r = lo; g = hi; b = hi; end
                    default: begin r = hi; g = lo; b = hi; end
                endcase
            end
            7: begin
                r = $urandom_range(0, 1) ? 8'hff : 8'h00;
                g = $urandom_range(0, 1) ? 8'hfe : 8'h01;
                b = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
            8: begin
                case ($urandom_range(0, 2))
                    0: begin r = lo; g = lo; b = hi; end
                    1: begin r = hi; g = lo; b = lo; end
                    default: begin r = lo; g = hi; b = lo; end
                endcase
            end
            9: begin
                // Largest plus smallest near half scale.
                hi = $urandom_range(128, 255);
                lo = t_chan'(CHAN_TOP - hi + $urandom_range(0, 1));
                mid = $urandom_range(lo, hi);
                case ($urandom_range(0, 5))
                    0: begin r = hi; g = mid; b = lo; end
                    1: begin r = hi; g = lo; b = mid; end
                    2: begin r = mid; g = hi; b = lo; end
                    3: begin r = lo; g = hi; b = mid; end
                    4: begin r = mid; g = lo; b = hi; end
                    default: begin r = lo; g = mid; b = hi; end
                endcase
            end
            default: ;
        endcase
    endtask

    initial begin
        int    sent;
        int    burst;
        bit    drained;
        t_chan r, g, b;
        sent = 0;
        drained = 1'b0;
        pix.valid = 1'b0;
        pix.red   = '0;
        pix.green = '0;
        pix.blue  = '0;
        hsl.ready = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_pixels[i]) begin
            send_pixel(corner_pixels[i][23:16], corner_pixels[i][15:8], corner_pixels[i][7:0]);
            hold_off($urandom_range(0, 1));
        end
        wait_for_results();

        while (sent < RANDOM_PIXELS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                random_pixel(r, g, b);
                send_pixel(r, g, b);
                sent++;
            end
            if (!drained && sent >= RANDOM_PIXELS / 2) begin
                wait_for_results();
                drained = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) hold_off($urandom_range(5, 15));
            else hold_off($urandom_range(0, 2));
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
